/* design/eor_pkg.sv */
// shared types, constants and microcode program of the ellipse outline rasterizer
// no dependencies; imported by every module of the block
package eor_pkg;

    // field widths
    localparam int COORD_W   = 13;
    localparam int POINT_W   = 14;
    localparam int SCREEN_W  = 13;
    localparam int EXT_W     = 11;
    localparam int SQ_W      = 22;
    localparam int TERM_W    = 48;
    localparam int GROW_W    = 24;
    localparam int PROD_W    = 36;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    // largest box extent, wider boxes are clamped
    localparam logic [EXT_W-1:0] MAX_EXTENT = 11'd1023;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [SCREEN_W-1:0]  SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0]  SCREEN_HEIGHT_RST = 13'd768;

    // input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // walk phase
    typedef enum logic [2:0] {
        PH_DONE = 3'b001,
        PH_MAIN = 3'b010,
        PH_TAIL = 3'b100
    } phase_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_MUL_AA,
        OP_MUL_BB,
        OP_MUL_XI,
        OP_GROW,
        OP_ERR,
        OP_FLAGS,
        OP_XSTEP,
        OP_XERR,
        OP_YSTEP,
        OP_YERR,
        OP_PHASE,
        OP_PH_DONE,
        OP_TSTEP
    } op_t;

    // result selection
    typedef enum logic [3:0] {
        E_NONE,
        E_DONE,
        E_M0,
        E_M1,
        E_M2,
        E_M3,
        E_T0,
        E_T1,
        E_T2,
        E_T3
    } emit_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_STEP,
        C_MAIN,
        C_TAIL
    } cond_t;

    localparam int PC_W = 5;

    // program entry points
    localparam logic [PC_W-1:0] UA_IDLE = 5'd0;
    localparam logic [PC_W-1:0] UA_STEP = 5'd7;
    localparam logic [PC_W-1:0] UA_MAIN = 5'd10;
    localparam logic [PC_W-1:0] UA_TAIL = 5'd19;

    typedef struct packed {
        op_t              op;
        emit_t            emit;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic  go;
        op_t   op;
        emit_t emit;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic phase_main;
        logic phase_tail;
        logic out_busy;
    } stat_t;

    // control store
    function automatic ucode_t eor_ucode(input logic [PC_W-1:0] addr);
        ucode_t u;
        begin
            u = '0;
            case (addr)
                // idle: take a transaction, steps branch to dispatch
                5'd0:
                begin
                    u.op = OP_LOAD;
                    u.cond = C_STEP;
                    u.target = UA_STEP;
                end
                // start setup
                5'd1: u.op = OP_SETUP;
                5'd2: u.op = OP_MUL_AA;
                5'd3: u.op = OP_MUL_BB;
                5'd4: u.op = OP_MUL_XI;
                5'd5: u.op = OP_GROW;
                5'd6:
                begin
                    u.op = OP_ERR;
                    u.cond = C_ALWAYS;
                    u.target = UA_IDLE;
                end
                // step dispatch on phase
                5'd7:
                begin
                    u.cond = C_MAIN;
                    u.target = UA_MAIN;
                end
                5'd8:
                begin
                    u.cond = C_TAIL;
                    u.target = UA_TAIL;
                end
                // finished: single done result
                5'd9:
                begin
                    u.op = OP_PH_DONE;
                    u.emit = E_DONE;
                    u.cond = C_ALWAYS;
                    u.target = UA_IDLE;
                end
                // main walk: four points then the error update
                5'd10: u.emit = E_M0;
                5'd11: u.emit = E_M1;
                5'd12: u.emit = E_M2;
                5'd13:
                begin
                    u.emit = E_M3;
                    u.op = OP_FLAGS;
                end
                5'd14: u.op = OP_XSTEP;
                5'd15: u.op = OP_XERR;
                5'd16: u.op = OP_YSTEP;
                5'd17: u.op = OP_YERR;
                5'd18:
                begin
                    u.op = OP_PHASE;
                    u.cond = C_ALWAYS;
                    u.target = UA_IDLE;
                end
                // tail: four points then move y outward
                5'd19: u.emit = E_T0;
                5'd20: u.emit = E_T1;
                5'd21: u.emit = E_T2;
                5'd22:
                begin
                    u.emit = E_T3;
                    u.op = OP_TSTEP;
                end
                5'd23:
                begin
                    u.op = OP_PHASE;
                    u.cond = C_ALWAYS;
                    u.target = UA_IDLE;
                end
                default:
                begin
                    u.cond = C_ALWAYS;
                    u.target = UA_IDLE;
                end
            endcase
            return u;
        end
    endfunction

endpackage

/* design/eor_seq.sv */
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on eor_pkg
module eor_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          action,
    input  eor_pkg::stat_t stat,
    output logic          in_stall,
    output eor_pkg::ctrl_t ctrl
);
    import eor_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          uw;
    logic            in_take;
    logic            hold_out;
    logic            go;
    logic            jump;

    // current control word
    assign uw = eor_ucode(pc_reg);

    // input is taken only at the idle step
    assign in_stall = (pc_reg != UA_IDLE);
    assign in_take  = in_valid && !in_stall;

    // a result step waits for the output register
    assign hold_out = (uw.emit != E_NONE) && stat.out_busy;
    assign go       = ((pc_reg != UA_IDLE) || in_take) && !hold_out;

    // jump condition
    always_comb
    begin
        case (uw.cond)
            C_NEVER:  jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_STEP:   jump = (action == ACT_STEP);
            C_MAIN:   jump = stat.phase_main;
            C_TAIL:   jump = stat.phase_tail;
            default:  jump = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (!go)
            pc_next = pc_reg;
        else if (jump)
            pc_next = uw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign ctrl.go   = go;
    assign ctrl.op   = uw.op;
    assign ctrl.emit = uw.emit;

endmodule

/* design/eor_datapath.sv */
// datapath: walk state, error terms, shared multiplier, config and output register
// depends on eor_pkg
module eor_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  eor_pkg::ctrl_t                       ctrl,
    output eor_pkg::stat_t                       stat,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_ax,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_ay,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_bx,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_by,
    input  logic                                 cfg_we,
    input  logic [eor_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [eor_pkg::CFG_DAT_W-1:0]        cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [eor_pkg::POINT_W-1:0]   point_x,
    output logic signed [eor_pkg::POINT_W-1:0]   point_y,
    output logic                                 in_bounds,
    output logic                                 done_res,
    output logic                                 last
);
    import eor_pkg::*;

    // configuration
    logic [SCREEN_W-1:0] sw_reg;
    logic [SCREEN_W-1:0] sh_reg;

    // captured corners
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    // walk state
    logic signed [POINT_W-1:0] lx_reg, rx_reg, ly_reg, uy_reg, miny_reg;
    logic [EXT_W-1:0]          a_reg, h_reg;
    logic [SQ_W-1:0]           aa_reg;
    logic signed [TERM_W-1:0]  xi_reg, yi_reg, err_reg;
    logic [GROW_W-1:0]         ag_reg, bg_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      cx_reg, cy_reg;
    phase_t                    phase_reg;

    // output register
    logic                      ov_reg;
    logic signed [POINT_W-1:0] px_reg, py_reg;
    logic                      inb_reg, done_reg, last_reg;

    logic fire;
    assign fire = ctrl.go;

    // setup arithmetic: ordered corners and clamped extents
    logic signed [POINT_W-1:0] dx, dy, ax_w, ay_w, bx_w, by_w;
    logic [POINT_W-1:0]        absx, absy;
    logic [EXT_W-1:0]          ext_a, ext_b, half_b;
    logic signed [POINT_W-1:0] ly_set;

    always_comb
    begin
        ax_w = {ax_reg[COORD_W-1], ax_reg};
        ay_w = {ay_reg[COORD_W-1], ay_reg};
        bx_w = {bx_reg[COORD_W-1], bx_reg};
        by_w = {by_reg[COORD_W-1], by_reg};
        dx = bx_w - ax_w;
        dy = by_w - ay_w;
        absx = dx[POINT_W-1] ? POINT_W'(-dx) : POINT_W'(dx);
        absy = dy[POINT_W-1] ? POINT_W'(-dy) : POINT_W'(dy);
        ext_a = (absx > {3'b000, MAX_EXTENT}) ? MAX_EXTENT : absx[EXT_W-1:0];
        ext_b = (absy > {3'b000, MAX_EXTENT}) ? MAX_EXTENT : absy[EXT_W-1:0];
        half_b = EXT_W'(({1'b0, h_reg} + 12'd1) >> 1);
        ly_set = miny_reg + $signed({3'b000, half_b});
    end

    // shared multiplier, operands picked by the operation
    logic signed [12:0]       mul_x;
    logic signed [22:0]       mul_y;
    logic signed [PROD_W-1:0] mul_p;

    always_comb
    begin
        case (ctrl.op)
            OP_MUL_AA:
            begin
                mul_x = $signed({2'b00, a_reg});
                mul_y = $signed({12'd0, a_reg});
            end
            OP_MUL_BB:
            begin
                mul_x = $signed({2'b00, h_reg});
                mul_y = $signed({12'd0, h_reg});
            end
            OP_MUL_XI:
            begin
                mul_x = 13'sd1 - $signed({2'b00, a_reg});
                mul_y = $signed({1'b0, prod_reg[SQ_W-1:0]});
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // walk decisions
    logic signed [TERM_W:0]    e2;
    logic                      cx_w, cy_w;
    logic signed [POINT_W-1:0] dy_walk;
    logic                      stay_main;

    always_comb
    begin
        e2 = {err_reg, 1'b0};
        cx_w = e2 >= $signed({xi_reg[TERM_W-1], xi_reg});
        cy_w = e2 <= $signed({yi_reg[TERM_W-1], yi_reg});
        dy_walk = ly_reg - uy_reg;
        stay_main = (phase_reg == PH_MAIN) && (lx_reg <= rx_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= SCREEN_WIDTH_RST;
            sh_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: sh_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_DONE;
        else if (fire)
        begin
            case (ctrl.op)
                OP_SETUP:   phase_reg <= PH_MAIN;
                OP_PH_DONE: phase_reg <= PH_DONE;
                OP_PHASE:
                begin
                    if (!stay_main)
                        phase_reg <= (dy_walk < $signed({3'b000, h_reg})) ? PH_TAIL : PH_DONE;
                end
                default:    ;
            endcase
        end
    end

    // walk state and error terms
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    ax_reg <= corner_ax;
                    ay_reg <= corner_ay;
                    bx_reg <= corner_bx;
                    by_reg <= corner_by;
                end
                OP_SETUP:
                begin
                    a_reg <= ext_a;
                    h_reg <= ext_b;
                    lx_reg <= (ax_w < bx_w) ? ax_w : bx_w;
                    miny_reg <= (ay_w < by_w) ? ay_w : by_w;
                end
                OP_MUL_AA:
                begin
                    prod_reg <= mul_p;
                    rx_reg <= lx_reg + $signed({3'b000, a_reg});
                    ly_reg <= ly_set;
                    uy_reg <= ly_set - $signed({13'd0, h_reg[0]});
                end
                OP_MUL_BB:
                begin
                    aa_reg <= prod_reg[SQ_W-1:0];
                    prod_reg <= mul_p;
                end
                OP_MUL_XI:
                begin
                    bg_reg <= {prod_reg[20:0], 3'b000};
                    prod_reg <= mul_p;
                end
                OP_GROW:
                begin
                    xi_reg <= {{10{prod_reg[PROD_W-1]}}, prod_reg, 2'b00};
                    yi_reg <= h_reg[0] ? $signed({23'd0, aa_reg, 3'b000})
                                       : $signed({24'd0, aa_reg, 2'b00});
                    ag_reg <= {aa_reg[20:0], 3'b000};
                end
                OP_ERR:
                begin
                    err_reg <= xi_reg + yi_reg
                             + (h_reg[0] ? $signed({26'd0, aa_reg}) : 48'sd0);
                end
                OP_FLAGS:
                begin
                    cx_reg <= cx_w;
                    cy_reg <= cy_w;
                end
                OP_XSTEP:
                begin
                    if (cx_reg)
                    begin
                        xi_reg <= xi_reg + $signed({24'd0, bg_reg});
                        lx_reg <= lx_reg + 14'sd1;
                        rx_reg <= rx_reg - 14'sd1;
                    end
                end
                OP_XERR:
                begin
                    if (cx_reg)
                        err_reg <= err_reg + xi_reg;
                end
                OP_YSTEP:
                begin
                    if (cy_reg)
                    begin
                        yi_reg <= yi_reg + $signed({24'd0, ag_reg});
                        ly_reg <= ly_reg + 14'sd1;
                        uy_reg <= uy_reg - 14'sd1;
                    end
                end
                OP_YERR:
                begin
                    if (cy_reg)
                        err_reg <= err_reg + yi_reg;
                end
                OP_TSTEP:
                begin
                    ly_reg <= ly_reg + 14'sd1;
                    uy_reg <= uy_reg - 14'sd1;
                end
                default: ;
            endcase
        end
    end

    // result selection
    logic signed [POINT_W-1:0] sel_x, sel_y;
    logic                      sel_last, sel_done, sel_inb;

    always_comb
    begin
        sel_last = 1'b0;
        sel_done = 1'b0;
        case (ctrl.emit)
            E_M0:
            begin
                sel_x = rx_reg;
                sel_y = ly_reg;
            end
            E_M1:
            begin
                sel_x = lx_reg;
                sel_y = ly_reg;
            end
            E_M2:
            begin
                sel_x = lx_reg;
                sel_y = uy_reg;
            end
            E_M3:
            begin
                sel_x = rx_reg;
                sel_y = uy_reg;
                sel_last = 1'b1;
            end
            E_T0:
            begin
                sel_x = lx_reg - 14'sd1;
                sel_y = ly_reg;
            end
            E_T1:
            begin
                sel_x = rx_reg + 14'sd1;
                sel_y = ly_reg;
            end
            E_T2:
            begin
                sel_x = lx_reg - 14'sd1;
                sel_y = uy_reg;
            end
            E_T3:
            begin
                sel_x = rx_reg + 14'sd1;
                sel_y = uy_reg;
                sel_last = 1'b1;
            end
            E_DONE:
            begin
                sel_x = '0;
                sel_y = '0;
                sel_last = 1'b1;
                sel_done = 1'b1;
            end
            default:
            begin
                sel_x = '0;
                sel_y = '0;
            end
        endcase
        sel_inb = !sel_done && !sel_x[POINT_W-1] && !sel_y[POINT_W-1]
                && ($unsigned(sel_x) < {1'b0, sw_reg})
                && ($unsigned(sel_y) < {1'b0, sh_reg});
    end

    // output register, holds while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (fire && (ctrl.emit != E_NONE))
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && (ctrl.emit != E_NONE))
        begin
            px_reg <= sel_x;
            py_reg <= sel_y;
            inb_reg <= sel_inb;
            done_reg <= sel_done;
            last_reg <= sel_last;
        end
    end

    assign out_valid = ov_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign in_bounds = inb_reg;
    assign done_res  = done_reg;
    assign last      = last_reg;

    assign stat.phase_main = (phase_reg == PH_MAIN);
    assign stat.phase_tail = (phase_reg == PH_TAIL);
    assign stat.out_busy   = ov_reg && out_stall;

endmodule

/* design/ellipse_outline_rasterizer.sv */
// top level of the ellipse outline rasterizer: sequencer plus datapath
// depends on eor_pkg, eor_seq, eor_datapath
//
// Midpoint ellipse outline walker for the box spanned by two corners. A start
// transaction (action 0) returns nothing; a main-walk step returns four points,
// a tail step four points, and a step after the outline is finished one done
// result; output stall holds the routine at a result step until the output
// register is free. In the microcode routines one shared 13x23 multiplier sets
// up a*a, b*b and the x error term over three steps, the error update takes four
// steps on one 48-bit adder, and each point passes one output register. A new
// transaction is taken only once the previous routine is back at its idle step.
// The user must write the screen size registers only while the block is idle;
// the block itself does not enforce this.
module ellipse_outline_rasterizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_ax,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_ay,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_bx,
    input  logic signed [eor_pkg::COORD_W-1:0]   corner_by,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [eor_pkg::POINT_W-1:0]   point_x,
    output logic signed [eor_pkg::POINT_W-1:0]   point_y,
    output logic                                 in_bounds,
    output logic                                 done_res,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [eor_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [eor_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import eor_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // control sequencer
    eor_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    // arithmetic and output
    eor_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .corner_ax (corner_ax),
        .corner_ay (corner_ay),
        .corner_bx (corner_bx),
        .corner_by (corner_by),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .in_bounds (in_bounds),
        .done_res  (done_res),
        .last      (last)
    );

endmodule

/* design/eor_checker.sv */
// port-level checks for the ellipse outline rasterizer, bound to the top level
// depends on eor_pkg and ellipse_outline_rasterizer
module eor_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [eor_pkg::POINT_W-1:0]   point_x,
    input logic signed [eor_pkg::POINT_W-1:0]   point_y,
    input logic                                 in_bounds,
    input logic                                 done_res,
    input logic                                 last
);
    import eor_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(in_bounds) && $stable(done_res) && $stable(last))
        else $error("stalled result changed");

    // an accepted transaction keeps the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transaction");

    // the done result is a lone last result with cleared point fields
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last && !in_bounds && (point_x == '0) && (point_y == '0))
        else $error("malformed done result");

    // an in-bounds point never has a negative coordinate
    a_inb_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_bounds |-> !point_x[POINT_W-1] && !point_y[POINT_W-1])
        else $error("negative point flagged in bounds");

endmodule

bind ellipse_outline_rasterizer eor_checker u_eor_checker (.*);

/* bench/tb_ellipse_outline_rasterizer.sv */
`timescale 1ns / 1ps
// testbench of ellipse_outline_rasterizer: directed transactions, then random outline walks
// every result is checked against an in-bench model of the midpoint walk; needs eor_pkg and the block
module tb_ellipse_outline_rasterizer;
    import eor_pkg::*;

    // one outline result as the block returns it
    typedef struct packed {
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
        logic                      inb;
        logic                      done_flag;
        logic                      last_flag;
    } outline_pt_t;

    // one directed transaction; typed_done rows expect the done result as typed here
    typedef struct packed {
        logic                      act;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic                      typed_done;
    } dir_row_t;

    localparam logic signed [COORD_W-1:0] COORD_MIN = -4096;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 4095;
    localparam outline_pt_t DONE_PT = '{px: '0, py: '0, inb: 1'b0,
                                        done_flag: 1'b1, last_flag: 1'b1};

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      action;
    logic signed [COORD_W-1:0] corner_ax;
    logic signed [COORD_W-1:0] corner_ay;
    logic signed [COORD_W-1:0] corner_bx;
    logic signed [COORD_W-1:0] corner_by;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic                      in_bounds;
    logic                      done_res;
    logic                      last;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DAT_W-1:0]      cfg_data;

    ellipse_outline_rasterizer uut (.*);

    // walk state of the in-bench model
    logic signed [POINT_W-1:0] walk_left;
    logic signed [POINT_W-1:0] walk_right;
    logic signed [POINT_W-1:0] walk_upper;
    logic signed [POINT_W-1:0] walk_lower;
    logic [EXT_W-1:0]          box_height;
    logic signed [TERM_W-1:0]  x_step_term;
    logic signed [TERM_W-1:0]  y_step_term;
    logic signed [TERM_W-1:0]  walk_error;
    logic [GROW_W-1:0]         xinc_growth;
    logic [GROW_W-1:0]         yinc_growth;
    phase_t                    walk_phase;
    logic [SCREEN_W-1:0]       screen_w;
    logic [SCREEN_W-1:0]       screen_h;

    outline_pt_t outline_q[$];
    int items_sent;
    int results_seen;
    int mismatch_count;
    int tx_idle_pct;
    int rx_idle_pct;

    // per random phase: sender and receiver idle rates, screen size, item count
    int tx_pct_tab[4] = '{28, 50, 0, 0};
    int rx_pct_tab[4] = '{50, 28, 0, 0};
    logic [CFG_DAT_W-1:0] width_tab[4] = '{13'd640, 13'd1, 13'd4096, 13'd8191};
    logic [CFG_DAT_W-1:0] height_tab[4] = '{13'd480, 13'd4096, 13'd0, 13'd8191};
    int seg_len_tab[4] = '{75, 75, 75, 60};

    dir_row_t dir_rows [25] = '{
        // steps straight out of reset give the done result
        '{ACT_STEP, 0, 0, 0, 0, 1'b1},
        '{ACT_STEP, 0, 0, 0, 0, 1'b1},
        // small box with reversed corners
        '{ACT_START, 10, 20, 4, 12, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        // zero-size box, one set of points then done
        '{ACT_START, 5, 5, 5, 5, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        // flat box of zero height
        '{ACT_START, 0, 0, 10, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        // widest box both ways round, extents clamp
        '{ACT_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        // box across the right and bottom screen edges
        '{ACT_START, 1020, 760, 1030, 770, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1'b0},
        '{ACT_START, 0, 0, 1, 1, 1'b0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] any_coord();
        return COORD_W'($urandom_range(0, 8191));
    endfunction

    // outline point with its screen test
    function automatic outline_pt_t make_point(input longint x, input longint y, input logic fin);
        outline_pt_t p;
        p.px = POINT_W'(x);
        p.py = POINT_W'(y);
        p.inb = (x >= 0) && (y >= 0) && (x < longint'(screen_w)) && (y < longint'(screen_h));
        p.done_flag = 1'b0;
        p.last_flag = fin;
        return p;
    endfunction

    // midpoint walk: applies one transaction to the model state, returns its result count
    function automatic int walk_item(input logic act, input logic signed [COORD_W-1:0] ax,
                                     input logic signed [COORD_W-1:0] ay,
                                     input logic signed [COORD_W-1:0] bx,
                                     input logic signed [COORD_W-1:0] by,
                                     output outline_pt_t pts [4]);
        longint a, b, odd, lx, rx, ly, uy, xi, yi, er, e2, gx, gy, hgt;
        int n;
        n = 0;
        lx = walk_left;
        rx = walk_right;
        ly = walk_lower;
        uy = walk_upper;
        xi = x_step_term;
        yi = y_step_term;
        er = walk_error;
        gx = xinc_growth;
        gy = yinc_growth;
        hgt = box_height;
        if (act == ACT_START)
        begin
            // order corners, clamp extents, set up the error terms
            a = longint'(bx) - longint'(ax);
            b = longint'(by) - longint'(ay);
            if (a < 0)
                a = -a;
            if (b < 0)
                b = -b;
            if (a > longint'(MAX_EXTENT))
                a = longint'(MAX_EXTENT);
            if (b > longint'(MAX_EXTENT))
                b = longint'(MAX_EXTENT);
            odd = b & 1;
            xi = 4 * (1 - a) * b * b;
            yi = 4 * (1 + odd) * a * a;
            er = xi + yi + odd * a * a;
            lx = (ax < bx) ? ax : bx;
            rx = lx + a;
            ly = ((ay < by) ? ay : by) + (b + 1) / 2;
            uy = ly - odd;
            gy = 8 * a * a;
            gx = 8 * b * b;
            hgt = b;
            walk_phase = PH_MAIN;
        end
        else if (walk_phase == PH_MAIN)
        begin
            // four symmetric points, then the error-driven move
            e2 = 2 * er;
            pts[0] = make_point(rx, ly, 1'b0);
            pts[1] = make_point(lx, ly, 1'b0);
            pts[2] = make_point(lx, uy, 1'b0);
            pts[3] = make_point(rx, uy, 1'b1);
            n = 4;
            if (e2 >= xi)
            begin
                lx++;
                rx--;
                xi += gx;
                er += xi;
            end
            if (e2 <= yi)
            begin
                ly++;
                uy--;
                yi += gy;
                er += yi;
            end
            if (lx > rx)
                walk_phase = (ly - uy < hgt) ? PH_TAIL : PH_DONE;
        end
        else if (walk_phase == PH_TAIL)
        begin
            // flat ellipse tail: points just outside the walk, y moves outward
            pts[0] = make_point(lx - 1, ly, 1'b0);
            pts[1] = make_point(rx + 1, ly, 1'b0);
            pts[2] = make_point(lx - 1, uy, 1'b0);
            pts[3] = make_point(rx + 1, uy, 1'b1);
            n = 4;
            ly++;
            uy--;
            walk_phase = (ly - uy < hgt) ? PH_TAIL : PH_DONE;
        end
        else
        begin
            walk_phase = PH_DONE;
            pts[0] = DONE_PT;
            n = 1;
        end
        walk_left = POINT_W'(lx);
        walk_right = POINT_W'(rx);
        walk_lower = POINT_W'(ly);
        walk_upper = POINT_W'(uy);
        x_step_term = TERM_W'(xi);
        y_step_term = TERM_W'(yi);
        walk_error = TERM_W'(er);
        xinc_growth = GROW_W'(gx);
        yinc_growth = GROW_W'(gy);
        box_height = EXT_W'(hgt);
        return n;
    endfunction

    // offer one transaction, wait for it to be taken, queue what it should return
    task automatic send_transaction(input logic act, input logic signed [COORD_W-1:0] ax,
                                    input logic signed [COORD_W-1:0] ay,
                                    input logic signed [COORD_W-1:0] bx,
                                    input logic signed [COORD_W-1:0] by,
                                    input logic typed_done);
        outline_pt_t pts [4];
        int n;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        corner_ax <= ax;
        corner_ay <= ay;
        corner_bx <= bx;
        corner_by <= by;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = walk_item(act, ax, ay, bx, by, pts);
        if (typed_done)
            outline_q.push_back(DONE_PT);
        else
            for (int k = 0; k < n; k++)
                outline_q.push_back(pts[k]);
        items_sent++;
    endtask

    task automatic send_step();
        send_transaction(ACT_STEP, any_coord(), any_coord(), any_coord(), any_coord(), 1'b0);
    endtask

    // stop offering until every queued result is back, then let the block settle
    task automatic drain_results(input int settle_cycles);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outline_q.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    // random outline walks with some loose transactions mixed in
    task automatic run_random(input int count);
        logic signed [COORD_W-1:0] ax, ay, bx, by;
        int stop_at, steps, pick, dx, dy;
        bit to_end;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                send_transaction(1'($urandom_range(0, 1)), any_coord(), any_coord(),
                                 any_coord(), any_coord(), 1'b0);
            end
            else
            begin
                // box position near the screen or anywhere
                if ($urandom_range(0, 1))
                begin
                    ax = COORD_W'($urandom_range(0, 1100));
                    ay = COORD_W'($urandom_range(0, 800));
                end
                else
                begin
                    ax = any_coord();
                    ay = any_coord();
                end
                // mostly small boxes, some flat ones, a few of any size
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    bx = any_coord();
                    by = any_coord();
                end
                else
                begin
                    if (pick < 25)
                    begin
                        dx = $urandom_range(0, 24);
                        dy = $urandom_range(0, 4);
                    end
                    else
                    begin
                        dx = $urandom_range(0, pick < 85 ? 12 : 60);
                        dy = $urandom_range(0, pick < 85 ? 12 : 60);
                    end
                    if ($urandom_range(0, 1))
                        dx = -dx;
                    if ($urandom_range(0, 1))
                        dy = -dy;
                    bx = COORD_W'(ax + dx);
                    by = COORD_W'(ay + dy);
                end
                send_transaction(ACT_START, ax, ay, bx, by, 1'b0);
                // walk to the end of the outline or abandon it part way
                to_end = $urandom_range(0, 99) < 60;
                steps = to_end ? 40 : $urandom_range(1, 8);
                for (int k = 0; k < steps && items_sent < stop_at
                     && !(to_end && walk_phase == PH_DONE); k++)
                    send_step();
                if (to_end && items_sent < stop_at)
                    repeat ($urandom_range(1, 2)) send_step();
            end
        end
    endtask

    // result checking and receiver stall
    initial
    begin
        outline_pt_t want;
        int hold_left;
        int hold_mark;
        out_stall = 1'b0;
        hold_left = 0;
        hold_mark = 150;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (outline_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: x=%0d y=%0d in=%0b done=%0b last=%0b",
                                 point_x, point_y, in_bounds, done_res, last);
                    mismatch_count++;
                end
                else
                begin
                    want = outline_q.pop_front();
                    if (point_x !== want.px || point_y !== want.py || in_bounds !== want.inb ||
                        done_res !== want.done_flag || last !== want.last_flag)
                    begin
                        if (mismatch_count < 10)
                            $display({"result mismatch: expected x=%0d y=%0d in=%0b done=%0b",
                                      " last=%0b, got x=%0d y=%0d in=%0b done=%0b last=%0b"},
                                     want.px, want.py, want.inb, want.done_flag,
                                     want.last_flag, point_x, point_y, in_bounds,
                                     done_res, last);
                        mismatch_count++;
                    end
                end
            end
            // long hold-offs now and then so the block backs up into its input
            if (hold_left == 0 && results_seen >= hold_mark)
            begin
                hold_left = 300;
                hold_mark += 450;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_START;
        corner_ax = '0;
        corner_ay = '0;
        corner_bx = '0;
        corner_by = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        results_seen = 0;
        mismatch_count = 0;
        tx_idle_pct = tx_pct_tab[0];
        rx_idle_pct = rx_pct_tab[0];

        // model state after reset
        walk_left = '0;
        walk_right = '0;
        walk_upper = '0;
        walk_lower = '0;
        box_height = '0;
        x_step_term = '0;
        y_step_term = '0;
        walk_error = '0;
        xinc_growth = '0;
        yinc_growth = '0;
        walk_phase = PH_DONE;
        screen_w = SCREEN_WIDTH_RST;
        screen_h = SCREEN_HEIGHT_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_transaction(dir_rows[i].act, dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].bx,
                             dir_rows[i].by, dir_rows[i].typed_done);

        // random phases, screen size rewritten while idle
        for (int s = 0; s < 4; s++)
        begin
            drain_results(12);
            tx_idle_pct = tx_pct_tab[s];
            rx_idle_pct = rx_pct_tab[s];
            cfg_we <= 1'b1;
            cfg_index <= CFG_SCREEN_WIDTH;
            cfg_data <= width_tab[s];
            @(posedge clk);
            cfg_index <= CFG_SCREEN_HEIGHT;
            cfg_data <= height_tab[s];
            @(posedge clk);
            cfg_we <= 1'b0;
            screen_w = width_tab[s];
            screen_h = height_tab[s];
            if (s == 1)
            begin
                // sender pauses mid-phase until everything is back
                run_random(seg_len_tab[s] / 2);
                drain_results(0);
                run_random(seg_len_tab[s] - seg_len_tab[s] / 2);
            end
            else
                run_random(seg_len_tab[s]);
        end

        drain_results(20);
        if (mismatch_count == 0 && outline_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
